// File: hdl/sao_pkg.sv
// Shared types, face-kind codes and arithmetic helpers for the shaded alpha over blend.
// No dependencies; every other file in hdl/ imports this package.
package sao_pkg;

   localparam int CHAN_W   = 8;
   localparam int NUM_CHAN = 3;
   localparam int PROD_W   = 2 * CHAN_W;
   localparam int WIDE_W   = 3 * CHAN_W;
   localparam int NUM_W    = PROD_W + 1;

   localparam logic [1:0] KIND_NORMAL = 2'd0;
   localparam logic [1:0] KIND_LIGHT  = 2'd1;
   localparam logic [1:0] KIND_SHADOW = 2'd2;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

   typedef struct packed {
      logic [1:0]        kind;
      logic [CHAN_W-1:0] src_red;
      logic [CHAN_W-1:0] src_green;
      logic [CHAN_W-1:0] src_blue;
      logic [CHAN_W-1:0] src_alpha;
      logic [CHAN_W-1:0] dst_red;
      logic [CHAN_W-1:0] dst_green;
      logic [CHAN_W-1:0] dst_blue;
      logic [CHAN_W-1:0] dst_alpha;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
      logic [CHAN_W-1:0] out_alpha;
   } rsp_type;

   // Numerators and combined alpha handed from the front end to the divider.
   typedef struct packed {
      logic                              valid;
      logic [CHAN_W-1:0]                 alpha;
      logic [NUM_CHAN-1:0][NUM_W-1:0]    num;
   } blend_type;

   // Exact x / 3 for any 9-bit x by reciprocal multiply.
   function automatic logic [CHAN_W-1:0] div3(input logic [CHAN_W:0] x);
      logic [19:0] p;
      p = 20'(x) * 20'd683;
      return p[18:11];
   endfunction

   function automatic logic [CHAN_W-1:0] shade(input logic [1:0] kind,
                                                input logic [CHAN_W-1:0] c);
      logic [CHAN_W-1:0] s;
      unique case (kind)
         KIND_LIGHT:  s = c + div3(9'(CHAN_MAX - c));
         KIND_SHADOW: s = div3({c, 1'b0});
         default:     s = c;
      endcase
      return s;
   endfunction

   // Exact x / 255 for a 24-bit x: reciprocal estimate low by at most one, then fix up.
   function automatic logic [PROD_W-1:0] div255(input logic [WIDE_W-1:0] x);
      logic [48:0] acc;
      logic [16:0] q;
      logic [24:0] back;
      logic [24:0] r;
      acc  = 49'(x) + (49'(x) << 8) + (49'(x) << 16) + (49'(x) << 24);
      q    = acc[48:32];
      back = (25'(q) << 8) - 25'(q);
      r    = 25'(x) - back;
      if (r >= 25'(CHAN_MAX)) begin
         q = q + 17'd1;
      end
      return q[PROD_W-1:0];
   endfunction

endpackage

// File: hdl/sao_prep.sv
// Front end: face shading, alpha combine and blend numerators in three register stages.
// Depends on sao_pkg.
module sao_prep (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               req_valid,
   input  sao_pkg::req_type   req_data,
   output sao_pkg::blend_type blend
);
   import sao_pkg::*;

   // stage 1: shaded source, destination colors, da * (255 - sa)
   logic                                s1_vld_ff;
   logic [NUM_CHAN-1:0][CHAN_W-1:0]     s1_sc_ff, s1_sc_in;
   logic [NUM_CHAN-1:0][CHAN_W-1:0]     s1_dc_ff, s1_dc_in;
   logic [CHAN_W-1:0]                   s1_sa_ff;
   logic [PROD_W-1:0]                   s1_pda_ff, s1_pda_in;

   // stage 2: combined alpha, source products, destination products
   logic                                s2_vld_ff;
   logic [CHAN_W-1:0]                   s2_alpha_ff, s2_alpha_in;
   logic [NUM_CHAN-1:0][PROD_W-1:0]     s2_scsa_ff, s2_scsa_in;
   logic [NUM_CHAN-1:0][WIDE_W-1:0]     s2_dcp_ff, s2_dcp_in;

   // stage 3: numerators
   logic                                s3_vld_ff;
   logic [CHAN_W-1:0]                   s3_alpha_ff;
   logic [NUM_CHAN-1:0][NUM_W-1:0]      s3_num_ff, s3_num_in;

   always_comb begin
      s1_sc_in[0] = shade(req_data.kind, req_data.src_red);
      s1_sc_in[1] = shade(req_data.kind, req_data.src_green);
      s1_sc_in[2] = shade(req_data.kind, req_data.src_blue);
      s1_dc_in[0] = req_data.dst_red;
      s1_dc_in[1] = req_data.dst_green;
      s1_dc_in[2] = req_data.dst_blue;
      s1_pda_in   = PROD_W'(req_data.dst_alpha) * PROD_W'(CHAN_MAX - req_data.src_alpha);
   end

   always_comb begin
      s2_alpha_in = s1_sa_ff + CHAN_W'(div255(WIDE_W'(s1_pda_ff)));
      for (int i = 0; i < NUM_CHAN; i++) begin
         s2_scsa_in[i] = PROD_W'(s1_sc_ff[i]) * PROD_W'(s1_sa_ff);
         s2_dcp_in[i]  = WIDE_W'(s1_dc_ff[i]) * WIDE_W'(s1_pda_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         s3_num_in[i] = NUM_W'(s2_scsa_ff[i]) + NUM_W'(div255(s2_dcp_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sc_ff    <= s1_sc_in;
         s1_dc_ff    <= s1_dc_in;
         s1_sa_ff    <= req_data.src_alpha;
         s1_pda_ff   <= s1_pda_in;
         s2_alpha_ff <= s2_alpha_in;
         s2_scsa_ff  <= s2_scsa_in;
         s2_dcp_ff   <= s2_dcp_in;
         s3_alpha_ff <= s2_alpha_ff;
         s3_num_ff   <= s3_num_in;
      end
   end

   assign blend.valid = s3_vld_ff;
   assign blend.alpha = s3_alpha_ff;
   assign blend.num   = s3_num_ff;

endmodule

// File: hdl/sao_divider.sv
// Pipelined restoring divider: three numerators by the shared alpha, two quotient
// bits per stage, saturating at 255. Depends on sao_pkg.
module sao_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  sao_pkg::blend_type blend,
   output logic               rsp_valid,
   output sao_pkg::rsp_type   rsp_data
);
   import sao_pkg::*;

   localparam int BITS_PER_STAGE = 2;
   localparam int STAGES         = CHAN_W / BITS_PER_STAGE;

   typedef struct packed {
      logic [CHAN_W-1:0] part;
      logic [CHAN_W-1:0] rest;
      logic [CHAN_W-1:0] quo;
   } lane_type;

   function automatic lane_type div_steps(input lane_type l, input logic [CHAN_W-1:0] d);
      lane_type        o;
      logic [CHAN_W:0] trial;
      o = l;
      for (int k = 0; k < BITS_PER_STAGE; k++) begin
         trial = {o.part, o.rest[CHAN_W-1]};
         if (trial >= {1'b0, d}) begin
            o.part = CHAN_W'(trial - {1'b0, d});
            o.quo  = {o.quo[CHAN_W-2:0], 1'b1};
         end else begin
            o.part = trial[CHAN_W-1:0];
            o.quo  = {o.quo[CHAN_W-2:0], 1'b0};
         end
         o.rest = {o.rest[CHAN_W-2:0], 1'b0};
      end
      return o;
   endfunction

   function automatic logic [CHAN_W-1:0] pick(input logic zero, input logic sat,
                                              input logic [CHAN_W-1:0] q);
      logic [CHAN_W-1:0] v;
      if (zero) begin
         v = '0;
      end else if (sat) begin
         v = CHAN_MAX;
      end else begin
         v = q;
      end
      return v;
   endfunction

   logic                                          vld_ff   [STAGES];
   logic [CHAN_W-1:0]                             alpha_ff [STAGES];
   logic                                          zero_ff  [STAGES];
   logic [NUM_CHAN-1:0]                           sat_ff   [STAGES];
   lane_type                                      lane_ff  [STAGES][NUM_CHAN];
   lane_type                                      lane_in  [STAGES][NUM_CHAN];
   lane_type                                      lane_init[NUM_CHAN];
   logic [NUM_CHAN-1:0]                           sat_init;

   // Seed lanes; a quotient of 256 or more is flagged and later forced to 255.
   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         sat_init[i]       = blend.num[i] >= {1'b0, blend.alpha, {CHAN_W{1'b0}}};
         lane_init[i].part = blend.num[i][NUM_W-2:CHAN_W];
         lane_init[i].rest = blend.num[i][CHAN_W-1:0];
         lane_init[i].quo  = '0;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         lane_in[0][i] = div_steps(lane_init[i], blend.alpha);
         for (int s = 1; s < STAGES; s++) begin
            lane_in[s][i] = div_steps(lane_ff[s-1][i], alpha_ff[s-1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= blend.valid;
         for (int s = 1; s < STAGES; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         alpha_ff[0] <= blend.alpha;
         zero_ff[0]  <= blend.alpha == '0;
         sat_ff[0]   <= sat_init;
         for (int s = 1; s < STAGES; s++) begin
            alpha_ff[s] <= alpha_ff[s-1];
            zero_ff[s]  <= zero_ff[s-1];
            sat_ff[s]   <= sat_ff[s-1];
         end
         lane_ff <= lane_in;
      end
   end

   assign rsp_valid          = vld_ff[STAGES-1];
   assign rsp_data.out_red   = pick(zero_ff[STAGES-1], sat_ff[STAGES-1][0],
                                    lane_ff[STAGES-1][0].quo);
   assign rsp_data.out_green = pick(zero_ff[STAGES-1], sat_ff[STAGES-1][1],
                                    lane_ff[STAGES-1][1].quo);
   assign rsp_data.out_blue  = pick(zero_ff[STAGES-1], sat_ff[STAGES-1][2],
                                    lane_ff[STAGES-1][2].quo);
   assign rsp_data.out_alpha = alpha_ff[STAGES-1];

endmodule

// File: hdl/shaded_alpha_over_blend.sv
// Top level of the shaded alpha over blend pipeline.
// Depends on sao_pkg, sao_prep and sao_divider.
//
// Usage:
//   The req_ channel carries one pixel job: face kind, base source RGBA and the
//   destination RGBA. Kind normal passes the source color, light lifts each color
//   channel by a third of its headroom, shadow keeps two thirds of it; alpha is
//   untouched. The shaded source is composited "over" the destination with
//   truncating division; a zero result alpha gives all zeros, a color channel
//   above 255 saturates.
//   The rsp_ channel returns the blended RGBA, one result per request, in order.
//   Seven register stages: three front-end stages (shade and products, alpha and
//   wide products, numerators by 255) and four divider stages retiring two
//   quotient bits each. Throughput is one transfer per cycle while the receiver
//   takes results, set by the fully pipelined divider.
//   When the receiver stalls with a result waiting, all stages hold and req_ready
//   drops; bubbles are not squeezed out. Reset clears every stage valid bit.
module shaded_alpha_over_blend (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sao_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sao_pkg::rsp_type rsp_data
);
   import sao_pkg::*;

   blend_type blend;
   logic      advance;

   // advance the whole pipeline unless a finished result is being held
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   sao_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_valid (req_valid),
      .req_data  (req_data),
      .blend     (blend)
   );

   sao_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .blend     (blend),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hdl/sao_checker.sv
// Port-level checks for shaded_alpha_over_blend and the bind that attaches them.
// Depends on sao_pkg.
module sao_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sao_pkg::rsp_type rsp_data
);
   import sao_pkg::*;

   // a held result blocks new transfers
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req_ready high while result stalled");

   // an empty output stage never blocks the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output");

   // zero combined alpha gives a fully zero pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_alpha == '0 |->
         rsp_data.out_red == '0 && rsp_data.out_green == '0 && rsp_data.out_blue == '0)
      else $error("nonzero color with zero alpha");

   // a stalled result holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // pipeline comes out of reset empty
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind shaded_alpha_over_blend sao_checker u_sao_checker (.*);
